// File: hdl/qclt_pkg.sv
package qclt_pkg;

   localparam int MaxResults = 3;
   localparam int ResIdxW    = 2;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;
   localparam logic [1:0] KIND_DONE  = 2'd3;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_FORMAT   = 2'd1;
   localparam logic [1:0] ERR_UNCLOSED = 2'd2;

   localparam logic [1:0] QUOTE_NONE   = 2'd0;
   localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
   localparam logic [1:0] QUOTE_SINGLE = 2'd2;

   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_LF        = 8'h0A;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_command;
   } req_data_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] token_byte;
      logic [1:0] error_code;
      logic       last_of_run;
   } rsp_data_type;

   typedef struct packed {
      logic       in_token;
      logic [1:0] quote_mode;
      logic       escape_pending;
      logic       single_quote_pending;
      logic       just_closed_quote;
      logic       error_latched;
   } state_type;

   typedef struct packed {
      rsp_data_type [MaxResults-1:0] entries;
      logic [ResIdxW-1:0]            count;
   } results_type;

endpackage

// File: hdl/quoted_command_line_tokenizer.sv
// Shell-style command line tokenizer.
// Input channel req_*: one command byte per transaction; end_of_command marks the
// final byte of a command. Output channel rsp_*: one result per transaction
// (token byte, token end, error, command done); last_of_run flags the final
// result caused by one input byte. A byte causing results gives one to three.
// Latency: results of a byte appear on rsp_* the cycle after it is accepted.
// Throughput: one byte per cycle while each byte causes at most one result and
// rsp_stall is low. A byte causing more results holds off the next byte until
// they drain, one entry a cycle through the result port while rsp_stall is low.
// A byte causing no result never stalls the input.
// Reset (synchronous, active high) clears the tokenizer state and drops any
// results not yet taken. While rsp_stall is high the current result holds;
// req_stall rises once the pending results cannot finish draining this cycle.
// After an error the rest of that command is consumed without results.
module quoted_command_line_tokenizer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  qclt_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output qclt_pkg::rsp_data_type rsp_data
);
   import qclt_pkg::*;

   state_type           state_ff;
   state_type           state_in;
   rsp_data_type        buf_ff [MaxResults];
   logic [ResIdxW-1:0]  cnt_ff;
   logic [ResIdxW-1:0]  idx_ff;
   results_type         results;
   logic                take;
   logic                take_last;
   logic                accept;

   qclt_step u_step (
      .state_in  (state_ff),
      .req_data  (req_data),
      .state_out (state_in),
      .results   (results)
   );

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = buf_ff[idx_ff];
   assign take      = rsp_valid && !rsp_stall;
   assign take_last = take && (idx_ff == cnt_ff - 2'd1);
   assign req_stall = rsp_valid && !take_last;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         cnt_ff   <= '0;
         idx_ff   <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         cnt_ff   <= results.count;
         idx_ff   <= '0;
      end else if (take_last) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (take) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < MaxResults; i++) begin
            buf_ff[i] <= results.entries[i];
         end
      end
   end

`ifndef SYNTHESIS
   a_idx_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> idx_ff < cnt_ff)
      else $error("result index beyond loaded count");

   a_last_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_of_run == (idx_ff == cnt_ff - 2'd1)))
      else $error("last_of_run does not match final loaded result");

   a_error_final : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_ERROR |-> rsp_data.last_of_run)
      else $error("error result is not the final result of its byte");

   a_accept_drain : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && rsp_valid |-> !rsp_stall && rsp_data.last_of_run)
      else $error("new byte accepted while results still pending");
`endif

endmodule

// File: hdl/qclt_step.sv
module qclt_step (
   input  qclt_pkg::state_type    state_in,
   input  qclt_pkg::req_data_type req_data,
   output qclt_pkg::state_type    state_out,
   output qclt_pkg::results_type  results
);
   import qclt_pkg::*;

   state_type           s;
   results_type         r;
   logic [ResIdxW-1:0]  n;
   logic                handled;
   logic [7:0]          c;
   logic                last;

   function automatic rsp_data_type make_entry(logic [1:0] kind, logic [7:0] data,
                                                logic [1:0] code);
      rsp_data_type e;
      e.result_kind = kind;
      e.token_byte  = data;
      e.error_code  = code;
      e.last_of_run = 1'b0;
      return e;
   endfunction

   function automatic logic is_space(logic [7:0] ch);
      return ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_CR || ch == CHAR_LF;
   endfunction

   always_comb begin
      s       = state_in;
      r       = '0;
      n       = '0;
      handled = 1'b0;
      c       = req_data.char_in;
      last    = req_data.end_of_command;

      if (s.error_latched) begin
         if (last) begin
            s = '0;
         end
      end else begin
         if (s.single_quote_pending) begin
            s.single_quote_pending = 1'b0;
            if (c == CHAR_SQUOTE) begin
               r.entries[n] = make_entry(KIND_BYTE, c, ERR_NONE);
               n = n + 2'd1;
               handled = 1'b1;
            end else begin
               r.entries[n] = make_entry(KIND_END, 8'd0, ERR_NONE);
               n = n + 2'd1;
               s.in_token = 1'b0;
               s.quote_mode = QUOTE_NONE;
               s.just_closed_quote = 1'b1;
            end
         end
         if (!handled && s.escape_pending) begin
            s.escape_pending = 1'b0;
            r.entries[n] = make_entry(KIND_BYTE, c, ERR_NONE);
            n = n + 2'd1;
            handled = 1'b1;
         end
         if (!handled && s.in_token) begin
            handled = 1'b1;
            if (s.quote_mode == QUOTE_DOUBLE) begin
               if (c == CHAR_DQUOTE) begin
                  r.entries[n] = make_entry(KIND_END, 8'd0, ERR_NONE);
                  n = n + 2'd1;
                  s.in_token = 1'b0;
                  s.quote_mode = QUOTE_NONE;
                  s.just_closed_quote = 1'b1;
               end else if (c == CHAR_BACKSLASH) begin
                  if (last) begin
                     r.entries[n] = make_entry(KIND_ERROR, 8'd0, ERR_UNCLOSED);
                     n = n + 2'd1;
                     s.error_latched = 1'b1;
                  end else begin
                     s.escape_pending = 1'b1;
                  end
               end else begin
                  r.entries[n] = make_entry(KIND_BYTE, c, ERR_NONE);
                  n = n + 2'd1;
               end
            end else if (s.quote_mode == QUOTE_SINGLE) begin
               if (c == CHAR_SQUOTE) begin
                  s.single_quote_pending = 1'b1;
               end else begin
                  r.entries[n] = make_entry(KIND_BYTE, c, ERR_NONE);
                  n = n + 2'd1;
               end
            end else begin
               if (is_space(c)) begin
                  r.entries[n] = make_entry(KIND_END, 8'd0, ERR_NONE);
                  n = n + 2'd1;
                  s.in_token = 1'b0;
                  s.quote_mode = QUOTE_NONE;
                  s.just_closed_quote = 1'b0;
               end else if (c == CHAR_DQUOTE) begin
                  r.entries[n] = make_entry(KIND_ERROR, 8'd0, ERR_FORMAT);
                  n = n + 2'd1;
                  s.error_latched = 1'b1;
               end else begin
                  r.entries[n] = make_entry(KIND_BYTE, c, ERR_NONE);
                  n = n + 2'd1;
               end
            end
         end
         if (!handled) begin
            if (is_space(c)) begin
               s.just_closed_quote = 1'b0;
            end else if (s.just_closed_quote) begin
               r.entries[n] = make_entry(KIND_ERROR, 8'd0, ERR_FORMAT);
               n = n + 2'd1;
               s.error_latched = 1'b1;
            end else begin
               s.in_token = 1'b1;
               if (c == CHAR_DQUOTE) begin
                  s.quote_mode = QUOTE_DOUBLE;
               end else if (c == CHAR_SQUOTE) begin
                  s.quote_mode = QUOTE_SINGLE;
               end else begin
                  s.quote_mode = QUOTE_NONE;
                  r.entries[n] = make_entry(KIND_BYTE, c, ERR_NONE);
                  n = n + 2'd1;
               end
            end
         end

         if (last) begin
            if (!s.error_latched) begin
               if (s.single_quote_pending) begin
                  s.single_quote_pending = 1'b0;
                  r.entries[n] = make_entry(KIND_END, 8'd0, ERR_NONE);
                  n = n + 2'd1;
                  s.in_token = 1'b0;
                  s.quote_mode = QUOTE_NONE;
                  s.just_closed_quote = 1'b1;
               end
               if (s.in_token) begin
                  if (s.quote_mode != QUOTE_NONE) begin
                     r.entries[n] = make_entry(KIND_ERROR, 8'd0, ERR_UNCLOSED);
                     n = n + 2'd1;
                     s.error_latched = 1'b1;
                  end else begin
                     r.entries[n] = make_entry(KIND_END, 8'd0, ERR_NONE);
                     n = n + 2'd1;
                     s.in_token = 1'b0;
                  end
               end
               if (!s.error_latched) begin
                  r.entries[n] = make_entry(KIND_DONE, 8'd0, ERR_NONE);
                  n = n + 2'd1;
               end
            end
            s = '0;
         end

         if (n != '0) begin
            r.entries[n - 2'd1].last_of_run = 1'b1;
         end
      end
      r.count = n;
   end

   assign state_out = s;
   assign results   = r;

endmodule
